FILE: design/tfn_pkg.sv
// Shared types and constants for the tensor Frobenius norm pipeline.
package tfn_pkg;

    localparam int NUM_COMP = 9;
    localparam int SYM_COMP = 6;
    localparam int NORM_W   = 17;
    localparam logic [NORM_W-1:0] NORM_MAX = '1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FULL_TENSOR   = 2'd0,
        CFG_PACKING_ORDER = 2'd1,
        CFG_USE_MASK      = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic full_tensor;
        logic packing_order;
        logic use_mask;
    } t_cfg;

endpackage

FILE: design/tensor_frobenius_norm_core.sv
// Top level: Frobenius norm of a 3x3 tensor, one voxel word per cycle unless the output stalls.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------
//  input    | in        | i_valid / o_ready  | i_comp0..i_comp8, i_inside_mask
//  result   | out       | o_valid / i_ready  | o_norm
//  config   | in        | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// One word enters per cycle while the output is not stalled; the pipeline holds
// two square stages, two adder-tree stages, one square-root stage per root bit
// (COMP_WIDTH + 1) and a clamp/output register.
// Synchronous active-low reset empties every stage and clears the config registers.
// Each stage advances when it is empty or its successor advances, so a stall at
// the output fills bubbles first and holds every word in place.
module tensor_frobenius_norm_core import tfn_pkg::*; #(
    parameter int COMP_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [COMP_WIDTH-1:0] i_comp0,
    input  logic [COMP_WIDTH-1:0] i_comp1,
    input  logic [COMP_WIDTH-1:0] i_comp2,
    input  logic [COMP_WIDTH-1:0] i_comp3,
    input  logic [COMP_WIDTH-1:0] i_comp4,
    input  logic [COMP_WIDTH-1:0] i_comp5,
    input  logic [COMP_WIDTH-1:0] i_comp6,
    input  logic [COMP_WIDTH-1:0] i_comp7,
    input  logic [COMP_WIDTH-1:0] i_comp8,
    input  logic                  i_inside_mask,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [NORM_W-1:0]     o_norm
);

    localparam int SUM_W = 2*COMP_WIDTH + 2;

    t_cfg                    r_cfg;
    logic [COMP_WIDTH-1:0]   comp [NUM_COMP];
    logic                    sq_valid;
    logic                    sq_ready;
    logic [2*COMP_WIDTH-1:0] sq [NUM_COMP];
    logic [NUM_COMP-1:0]     sq_dbl;
    logic                    sum_valid;
    logic                    sum_ready;
    logic [SUM_W-1:0]        sum;

    // Write config; indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FULL_TENSOR:   r_cfg.full_tensor   <= i_cfg_data[0];
                CFG_PACKING_ORDER: r_cfg.packing_order <= i_cfg_data[0];
                CFG_USE_MASK:      r_cfg.use_mask      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign comp[0] = i_comp0;
    assign comp[1] = i_comp1;
    assign comp[2] = i_comp2;
    assign comp[3] = i_comp3;
    assign comp[4] = i_comp4;
    assign comp[5] = i_comp5;
    assign comp[6] = i_comp6;
    assign comp[7] = i_comp7;
    assign comp[8] = i_comp8;

    tfn_square #(
        .COMP_WIDTH (COMP_WIDTH)
    ) u_square (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_comp        (comp),
        .i_inside_mask (i_inside_mask),
        .o_valid       (sq_valid),
        .i_ready       (sq_ready),
        .o_sq          (sq),
        .o_dbl         (sq_dbl)
    );

    tfn_sum #(
        .COMP_WIDTH (COMP_WIDTH),
        .SUM_W      (SUM_W)
    ) u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid),
        .o_ready (sq_ready),
        .i_sq    (sq),
        .i_dbl   (sq_dbl),
        .o_valid (sum_valid),
        .i_ready (sum_ready),
        .o_sum   (sum)
    );

    tfn_isqrt #(
        .SUM_W (SUM_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sum_valid),
        .o_ready (sum_ready),
        .i_sum   (sum),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_norm  (o_norm)
    );

endmodule

FILE: design/tfn_square.sv
// Stages 1-2: component magnitudes with weight selection, then squares.
module tfn_square import tfn_pkg::*; #(
    parameter int COMP_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [COMP_WIDTH-1:0] i_comp [NUM_COMP],
    input  logic                  i_inside_mask,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [2*COMP_WIDTH-1:0] o_sq [NUM_COMP],
    output logic [NUM_COMP-1:0]   o_dbl
);

    logic                  r_v1;
    logic                  r_v2;
    logic                  s2_ready;
    logic [COMP_WIDTH-1:0] r_mag [NUM_COMP];
    logic [NUM_COMP-1:0]   r_dbl1;
    logic [2*COMP_WIDTH-1:0] r_sq [NUM_COMP];
    logic [NUM_COMP-1:0]   r_dbl2;
    logic [COMP_WIDTH-1:0] n_mag [NUM_COMP];
    logic [NUM_COMP-1:0]   n_dbl;

    assign s2_ready = !r_v2 || i_ready;
    assign o_ready  = !r_v1 || s2_ready;

    // Zero the magnitude of unused or masked components so they drop out of the sum.
    always_comb begin
        logic masked;
        logic used;
        masked = i_cfg.use_mask && !i_inside_mask;
        for (int i = 0; i < NUM_COMP; i++) begin
            used = i_cfg.full_tensor || (i < SYM_COMP);
            n_mag[i] = (masked || !used) ? '0 :
                       (i_comp[i][COMP_WIDTH-1] ? (~i_comp[i] + 1'b1) : i_comp[i]);
            if (i_cfg.full_tensor) begin
                n_dbl[i] = 1'b0;
            end else if (i_cfg.packing_order) begin
                n_dbl[i] = (i >= 3) && (i < SYM_COMP);
            end else begin
                n_dbl[i] = (i == 1) || (i == 2) || (i == 4);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (o_ready) r_v1 <= i_valid;
            if (s2_ready) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_mag  <= n_mag;
            r_dbl1 <= n_dbl;
        end
        if (s2_ready && r_v1) begin
            for (int i = 0; i < NUM_COMP; i++) begin
                r_sq[i] <= (2*COMP_WIDTH)'(r_mag[i]) * (2*COMP_WIDTH)'(r_mag[i]);
            end
            r_dbl2 <= r_dbl1;
        end
    end

    assign o_valid = r_v2;
    assign o_sq    = r_sq;
    assign o_dbl   = r_dbl2;

endmodule

FILE: design/tfn_sum.sv
// Stages 3-4: weighted sum of squares as a two-level registered adder tree.
module tfn_sum import tfn_pkg::*; #(
    parameter int COMP_WIDTH = 16,
    parameter int SUM_W      = 2*COMP_WIDTH + 2
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [2*COMP_WIDTH-1:0] i_sq [NUM_COMP],
    input  logic [NUM_COMP-1:0]     i_dbl,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [SUM_W-1:0]        o_sum
);

    localparam int NUM_GRP = NUM_COMP / 3;

    logic             r_v1;
    logic             r_v2;
    logic             s2_ready;
    logic [SUM_W-1:0] r_part [NUM_GRP];
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] n_part [NUM_GRP];
    logic [SUM_W-1:0] n_sum;

    assign s2_ready = !r_v2 || i_ready;
    assign o_ready  = !r_v1 || s2_ready;

    // Off-diagonal entries count twice: add the square shifted up by one.
    always_comb begin
        logic [SUM_W-1:0] term;
        for (int k = 0; k < NUM_GRP; k++) begin
            n_part[k] = '0;
            for (int j = 0; j < 3; j++) begin
                term = SUM_W'(i_sq[3*k+j]);
                n_part[k] = n_part[k] + (i_dbl[3*k+j] ? (term << 1) : term);
            end
        end
        n_sum = '0;
        for (int k = 0; k < NUM_GRP; k++) begin
            n_sum = n_sum + r_part[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (o_ready) r_v1 <= i_valid;
            if (s2_ready) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_part <= n_part;
        if (s2_ready && r_v1) r_sum <= n_sum;
    end

    assign o_valid = r_v2;
    assign o_sum   = r_sum;

endmodule

FILE: design/tfn_sqrt_step.sv
// One registered digit step of the restoring integer square root.
module tfn_sqrt_step #(
    parameter int SUM_W  = 34,
    parameter int ROOT_W = SUM_W / 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [SUM_W-1:0]  i_n,
    input  logic [ROOT_W+1:0] i_rem,
    input  logic [ROOT_W-1:0] i_q,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [SUM_W-1:0]  o_n,
    output logic [ROOT_W+1:0] o_rem,
    output logic [ROOT_W-1:0] o_q
);

    logic              r_valid;
    logic [SUM_W-1:0]  r_n;
    logic [ROOT_W+1:0] r_rem;
    logic [ROOT_W-1:0] r_q;
    logic [ROOT_W+1:0] rem_sh;
    logic [ROOT_W+1:0] trial;
    logic              fits;

    assign o_ready = !r_valid || i_ready;

    // Bring down the next two bits of the radicand and try root digit one.
    assign rem_sh = {i_rem[ROOT_W-1:0], i_n[SUM_W-1 -: 2]};
    assign trial  = {i_q, 2'b01};
    assign fits   = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_n   <= i_n << 2;
            r_rem <= fits ? (rem_sh - trial) : rem_sh;
            r_q   <= {i_q[ROOT_W-2:0], fits};
        end
    end

    assign o_valid = r_valid;
    assign o_n     = r_n;
    assign o_rem   = r_rem;
    assign o_q     = r_q;

endmodule

FILE: design/tfn_isqrt.sv
// Pipelined floor square root, one root bit per stage, with output clamp.
module tfn_isqrt import tfn_pkg::*; #(
    parameter int SUM_W = 34
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [SUM_W-1:0]  i_sum,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [NORM_W-1:0] o_norm
);

    localparam int ROOT_W = SUM_W / 2;
    localparam int QX_W   = (ROOT_W > NORM_W) ? ROOT_W : NORM_W;

    logic              vld [ROOT_W+1];
    logic              rdy [ROOT_W+1];
    logic [SUM_W-1:0]  nn  [ROOT_W+1];
    logic [ROOT_W+1:0] rem [ROOT_W+1];
    logic [ROOT_W-1:0] q   [ROOT_W+1];

    logic              r_valid;
    logic [NORM_W-1:0] r_norm;
    logic [QX_W-1:0]   q_ext;
    logic [NORM_W-1:0] n_norm;
    logic [ROOT_W+1:0] unused_rem;
    logic [SUM_W-1:0]  unused_n;

    assign vld[0] = i_valid;
    assign nn[0]  = i_sum;
    assign rem[0] = '0;
    assign q[0]   = '0;
    assign o_ready = rdy[0];

    for (genvar g = 0; g < ROOT_W; g++) begin : g_step
        tfn_sqrt_step #(
            .SUM_W  (SUM_W),
            .ROOT_W (ROOT_W)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (vld[g]),
            .o_ready (rdy[g]),
            .i_n     (nn[g]),
            .i_rem   (rem[g]),
            .i_q     (q[g]),
            .o_valid (vld[g+1]),
            .i_ready (rdy[g+1]),
            .o_n     (nn[g+1]),
            .o_rem   (rem[g+1]),
            .o_q     (q[g+1])
        );
    end

    // The final remainder and the spent radicand carry nothing further.
    assign unused_rem = rem[ROOT_W];
    assign unused_n   = nn[ROOT_W];

    assign rdy[ROOT_W] = !r_valid || i_ready;

    // Clamp roots that do not fit the result field (wide components only).
    assign q_ext  = QX_W'(q[ROOT_W]);
    assign n_norm = (q_ext > QX_W'(NORM_MAX)) ? NORM_MAX : q_ext[NORM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (rdy[ROOT_W]) begin
            r_valid <= vld[ROOT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[ROOT_W] && vld[ROOT_W]) r_norm <= n_norm;
    end

    assign o_valid = r_valid;
    assign o_norm  = r_norm;

endmodule

FILE: tb/sv/tfn_checker.sv
`timescale 1ns / 1ps
// Checker for the Frobenius norm core: tracks registers, predicts each norm, compares results.
module tfn_checker import tfn_pkg::*; #(
    parameter int COMP_WIDTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0]                 i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]                i_cfg_data,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_ready,
    input  logic [NUM_COMP-1:0][COMP_WIDTH-1:0]  i_comps,
    input  logic                                 i_in_mask,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_ready,
    input  logic [NORM_W-1:0]                    i_norm,
    output int                                   o_pending,
    output int                                   o_fail_count,
    output int                                   o_checked
);

    localparam int REPORT_MAX = 10;

    t_cfg              cfg_q;
    logic [NORM_W-1:0] norm_expect_q[$];
    logic [NORM_W-1:0] norm_exp;

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
        o_checked    = 0;
        cfg_q        = '0;
    end

    function automatic logic [NORM_W-1:0] predict_norm(
        input t_cfg                                cfg,
        input logic [NUM_COMP-1:0][COMP_WIDTH-1:0] v,
        input logic                                in_mask
    );
        longint unsigned         sum_sq;
        longint unsigned         mag;
        longint unsigned         weight;
        longint unsigned         trial;
        longint unsigned         root;
        logic [COMP_WIDTH-1:0]   neg;
        if (cfg.use_mask && !in_mask) begin
            return '0;
        end
        sum_sq = 0;
        for (int i = 0; i < NUM_COMP; i++) begin
            if (cfg.full_tensor) begin
                weight = 1;
            end else if (i >= SYM_COMP) begin
                weight = 0;
            end else if (!cfg.packing_order) begin
                // xx,xy,xz,yy,yz,zz: off-diagonals sit in lanes 1, 2 and 4
                weight = (i == 1 || i == 2 || i == 4) ? 2 : 1;
            end else begin
                // xx,yy,zz,xy,yz,xz: off-diagonals fill the upper half
                weight = (i >= 3) ? 2 : 1;
            end
            neg = ~v[i] + 1'b1;
            mag = v[i][COMP_WIDTH-1] ? neg : v[i];
            sum_sq += weight * mag * mag;
        end
        // build the root one bit at a time from the top
        root = 0;
        for (int b = NORM_W; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= sum_sq) begin
                root = trial;
            end
        end
        if (root > NORM_MAX) begin
            root = NORM_MAX;
        end
        return root[NORM_W-1:0];
    endfunction

    task automatic note_failure(input string msg);
        o_fail_count++;
        if (o_fail_count <= REPORT_MAX) begin
            $display("%0t ns: norm mismatch: %s", $realtime, msg);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_q = '0;
            norm_expect_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FULL_TENSOR:   cfg_q.full_tensor   = i_cfg_data[0];
                    CFG_PACKING_ORDER: cfg_q.packing_order = i_cfg_data[0];
                    CFG_USE_MASK:      cfg_q.use_mask      = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                norm_expect_q.push_back(predict_norm(cfg_q, i_comps, i_in_mask));
            end
            if (i_out_valid && i_out_ready) begin
                if (norm_expect_q.size() == 0) begin
                    note_failure($sformatf("unexpected word, actual %0d", i_norm));
                end else begin
                    norm_exp = norm_expect_q.pop_front();
                    o_checked++;
                    if (i_norm !== norm_exp) begin
                        note_failure($sformatf("result %0d: expected %0d, actual %0d",
                                               o_checked, norm_exp, i_norm));
                    end
                end
            end
        end
        o_pending = norm_expect_q.size();
    end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Testbench top: drives voxel words and register writes, gives the verdict.
module testbench;
    import tfn_pkg::*;

    localparam int COMP_W           = 16;
    localparam int RESET_CYCLES     = 11;
    localparam int LONG_HOLD        = 200;
    localparam int IDLE_LIMIT       = 2000;
    localparam int SETTLE_CYCLES    = 40;
    localparam int RAND_PER_SETTING = 156;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    typedef logic [NUM_COMP-1:0][COMP_W-1:0] t_voxel;

    localparam logic [COMP_W-1:0] COMP_MIN = {1'b1, {(COMP_W-1){1'b0}}};
    localparam logic [COMP_W-1:0] COMP_MAX = {1'b0, {(COMP_W-1){1'b1}}};

    // distinct magnitudes so that weights and lane order all show in the sum
    localparam t_voxel STAIRS = {16'sd9000, -16'sd8000, 16'sd7000, -16'sd6000, 16'sd5000,
                                 -16'sd4000, 16'sd3000, -16'sd2000, 16'sd1000};
    localparam t_voxel ZIGZAG = {COMP_MIN, COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN,
                                 COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN};

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    t_voxel                voxel;
    logic                  in_mask;
    logic                  out_valid;
    logic                  out_ready;
    logic [NORM_W-1:0]     norm;

    int   pending;
    int   fail_count;
    int   checked;
    int   words_sent;
    int   idle_cycles;
    logic no_gaps;
    logic long_hold_pending;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    tensor_frobenius_norm_core #(
        .COMP_WIDTH (COMP_W)
    ) u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_valid       (in_valid),
        .o_ready       (in_ready),
        .i_comp0       (voxel[0]),
        .i_comp1       (voxel[1]),
        .i_comp2       (voxel[2]),
        .i_comp3       (voxel[3]),
        .i_comp4       (voxel[4]),
        .i_comp5       (voxel[5]),
        .i_comp6       (voxel[6]),
        .i_comp7       (voxel[7]),
        .i_comp8       (voxel[8]),
        .i_inside_mask (in_mask),
        .o_valid       (out_valid),
        .i_ready       (out_ready),
        .o_norm        (norm)
    );

    tfn_checker #(
        .COMP_WIDTH (COMP_W)
    ) u_norm_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_comps      (voxel),
        .i_in_mask    (in_mask),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_norm       (norm),
        .o_pending    (pending),
        .o_fail_count (fail_count),
        .o_checked    (checked)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [COMP_W-1:0] rand_comp();
        logic [COMP_W-1:0] low_val;
        low_val = COMP_W'($urandom_range(0, 255));
        case ($urandom_range(0, 11))
            0:       return COMP_MIN;
            1:       return COMP_MAX;
            2:       return '0;
            3:       return '1;
            4:       return low_val;
            5:       return -low_val;
            default: return COMP_W'($urandom);
        endcase
    endfunction

    function automatic t_voxel same_voxel(input logic [COMP_W-1:0] x);
        t_voxel v;
        for (int i = 0; i < NUM_COMP; i++) begin
            v[i] = x;
        end
        return v;
    endfunction

    function automatic t_voxel rand_voxel();
        t_voxel v;
        if ($urandom_range(0, 19) == 0) begin
            return same_voxel(rand_comp());
        end
        for (int i = 0; i < NUM_COMP; i++) begin
            v[i] = rand_comp();
        end
        return v;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic apply_setting(input logic full, input logic pack, input logic mask_en);
        write_reg(CFG_FULL_TENSOR, full);
        write_reg(CFG_PACKING_ORDER, pack);
        write_reg(CFG_USE_MASK, mask_en);
    endtask

    // leave valid high after acceptance so words can follow back to back
    task automatic send_voxel(input t_voxel v, input logic m);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        voxel    <= v;
        in_mask  <= m;
        do @(posedge clk); while (!in_ready);
        words_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // result side: random back-pressure, plus a long hold-off on request
    initial begin
        int stall;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (long_hold_pending) begin
                long_hold_pending = 1'b0;
                stall = LONG_HOLD;
            end else if (no_gaps) begin
                stall = 0;
            end else begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 8) - 1) @(negedge clk);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, pending);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_idx           <= '0;
        cfg_data          <= '0;
        in_valid          <= 1'b0;
        voxel             <= '0;
        in_mask           <= 1'b0;
        out_ready         <= 1'b0;
        words_sent        = 0;
        idle_cycles       = 0;
        no_gaps           = 1'b0;
        long_hold_pending = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // reset setting: symmetric, first packing order, mask off
        send_voxel('0, 1'b1);
        send_voxel(same_voxel(COMP_MIN), 1'b1);
        send_voxel(same_voxel(COMP_MAX), 1'b0);
        send_voxel(STAIRS, 1'b1);
        send_voxel(ZIGZAG, 1'b0);
        drain();

        apply_setting(1'b0, 1'b1, 1'b0);
        send_voxel(same_voxel(COMP_MIN), 1'b1);
        send_voxel(STAIRS, 1'b0);
        send_voxel(ZIGZAG, 1'b1);
        drain();

        apply_setting(1'b1, 1'b0, 1'b0);
        send_voxel(same_voxel(COMP_MIN), 1'b1);
        send_voxel(same_voxel(COMP_MAX), 1'b1);
        send_voxel(STAIRS, 1'b0);
        send_voxel(ZIGZAG, 1'b1);
        send_voxel(same_voxel('1), 1'b1);
        drain();

        // a write to the spare index must leave full mode in place
        write_reg(CFG_IDX_SPARE, 1'b1);
        send_voxel(STAIRS, 1'b1);
        drain();

        apply_setting(1'b1, 1'b1, 1'b1);
        send_voxel(same_voxel(COMP_MIN), 1'b0);
        send_voxel(same_voxel(COMP_MIN), 1'b1);
        drain();

        apply_setting(1'b0, 1'b0, 1'b1);
        send_voxel(ZIGZAG, 1'b0);
        send_voxel(ZIGZAG, 1'b1);
        send_voxel(STAIRS, 1'b1);
        drain();

        for (int s = 0; s < 8; s++) begin
            apply_setting(s[2], s[1], s[0]);
            no_gaps = (s == 2 || s == 4);
            for (int n = 0; n < RAND_PER_SETTING; n++) begin
                if (n == 10 && (s == 2 || s == 6)) begin
                    long_hold_pending = 1'b1;
                end
                send_voxel(rand_voxel(), 1'($urandom_range(0, 1)));
            end
            drain();
        end
        no_gaps = 1'b0;

        $display("covered %0d voxel words over all eight register settings, with extreme",
                 words_sent);
        $display("components, masked voxels and %0d-cycle output stalls; %0d norms checked",
                 LONG_HOLD, checked);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
